### src/cbm_pkg.sv
package cbm_pkg;

    localparam int RamBankBytes = 8192;
    localparam int RomBankBytes = 16384;
    localparam int RamOffW      = $clog2(RamBankBytes);
    localparam int RomOffW      = $clog2(RomBankBytes);

    // bus region, address[15:13]; regions above RGN_ROM_HI are the save RAM window
    localparam logic [2:0] RGN_RAM_EN   = 3'd0;
    localparam logic [2:0] RGN_ROM_BANK = 3'd1;
    localparam logic [2:0] RGN_RAM_BANK = 3'd2;
    localparam logic [2:0] RGN_MODE     = 3'd3;
    localparam logic [2:0] RGN_ROM_HI   = 3'd4;

    // configuration register indexes
    localparam logic CFG_MAPPER_IS_MBC1 = 1'b0;
    localparam logic CFG_RAM_BANK_COUNT = 1'b1;

    localparam logic ACC_READ  = 1'b0;
    localparam logic ACC_WRITE = 1'b1;

    localparam logic [3:0] RAM_EN_KEY = 4'hA;
    localparam logic [7:0] OPEN_BUS   = 8'hFF;

    typedef struct packed {
        logic                rom_fetch;
        logic [18:0]         rom_address;
        logic                ram_rd;
        logic                ram_wr;
        logic [1:0]          bank;
        logic [RamOffW-1:0]  offset;
        logic [7:0]          fill;
    } t_req;

endpackage

### src/cbm_ram.sv
module cbm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32768
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

### src/cbm_ctrl.sv
module cbm_ctrl
    import cbm_pkg::*;
#(
    parameter int SAVE_BANKS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [2:0]  i_cfg_data,
    input  logic        i_accept,
    input  logic        i_mode,
    input  logic [15:0] i_address,
    input  logic [7:0]  i_write_data,
    output t_req        o_req
);

    localparam logic [2:0] BankLimit = 3'(SAVE_BANKS);

    logic       r_is_mbc1;
    logic [2:0] r_bank_count;
    logic       r_ram_enable;
    logic [4:0] r_rom_bank;
    logic [1:0] r_ram_sel;
    logic       r_bank_mode;
    logic [1:0] r_active;

    logic       n_ram_enable;
    logic [4:0] n_rom_bank;
    logic [1:0] n_ram_sel;
    logic       n_bank_mode;
    logic [1:0] n_active;

    logic [2:0] w_rgn;
    logic [2:0] w_count;
    logic       w_ram_ok;
    logic [1:0] w_bank;

    assign w_rgn   = i_address[15:13];
    assign w_count = (r_bank_count > BankLimit) ? BankLimit : r_bank_count;
    assign w_ram_ok = r_ram_enable && (r_bank_count != 3'd0);

    always_comb begin
        if (w_count >= 3'd4) begin
            w_bank = r_active;
        end else if (w_count >= 3'd2) begin
            w_bank = {1'b0, r_active[0]};
        end else begin
            w_bank = 2'd0;
        end
    end

    always_comb begin
        n_ram_enable = r_ram_enable;
        n_rom_bank   = r_rom_bank;
        n_ram_sel    = r_ram_sel;
        n_bank_mode  = r_bank_mode;
        n_active     = r_active;

        o_req             = '0;
        o_req.bank        = w_bank;
        o_req.offset      = i_address[RamOffW-1:0];

        if (!r_is_mbc1) begin
            if (i_mode == ACC_READ) begin
                o_req.rom_fetch   = 1'b1;
                o_req.rom_address = {3'd0, i_address};
            end
        end else if (i_mode == ACC_WRITE) begin
            unique case (w_rgn)
                RGN_RAM_EN: begin
                    n_ram_enable = (i_write_data[3:0] == RAM_EN_KEY);
                end
                RGN_ROM_BANK: begin
                    n_rom_bank = (i_write_data[4:0] == 5'd0) ? 5'd1 : i_write_data[4:0];
                end
                RGN_RAM_BANK: begin
                    n_ram_sel = i_write_data[1:0];
                    if (r_bank_mode) begin
                        n_active = i_write_data[1:0];
                    end
                end
                RGN_MODE: begin
                    n_bank_mode = i_write_data[0];
                    if (i_write_data[0]) begin
                        n_active = r_ram_sel;
                    end
                end
                RGN_ROM_HI: begin
                end
                default: begin
                    o_req.ram_wr = w_ram_ok;
                end
            endcase
        end else begin
            unique case (w_rgn)
                RGN_RAM_EN, RGN_ROM_BANK: begin
                    o_req.rom_fetch   = 1'b1;
                    o_req.rom_address = {3'd0, i_address};
                end
                RGN_RAM_BANK, RGN_MODE, RGN_ROM_HI: begin
                    o_req.rom_fetch   = 1'b1;
                    o_req.rom_address = {r_rom_bank, i_address[RomOffW-1:0]};
                end
                default: begin
                    o_req.ram_rd = w_ram_ok;
                    o_req.fill   = w_ram_ok ? 8'h00 : OPEN_BUS;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_is_mbc1    <= 1'b1;
            r_bank_count <= 3'd0;
            r_ram_enable <= 1'b0;
            r_rom_bank   <= 5'd1;
            r_ram_sel    <= 2'd0;
            r_bank_mode  <= 1'b0;
            r_active     <= 2'd0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_MAPPER_IS_MBC1: r_is_mbc1    <= i_cfg_data[0];
                    CFG_RAM_BANK_COUNT: r_bank_count <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (i_accept) begin
                r_ram_enable <= n_ram_enable;
                r_rom_bank   <= n_rom_bank;
                r_ram_sel    <= n_ram_sel;
                r_bank_mode  <= n_bank_mode;
                r_active     <= n_active;
            end
        end
    end

endmodule

### src/cartridge_bank_mapper_core.sv
// Channel  | Direction | Word                                     | Handshake
// ---------+-----------+------------------------------------------+--------------------------
// access   | in        | i_mode, i_address, i_write_data          | i_in_valid / o_in_ready
// result   | out       | o_read_data, o_rom_fetch, o_rom_address  | o_out_valid / i_out_ready
// config   | in        | i_cfg_index, i_cfg_data                  | i_cfg_we
//
// One access per cycle unless stalled; an access taken loads the save RAM read and
// stage register at the accepting edge, and the output register then takes the result.
// After reset the save RAM is swept to zero, one byte per cycle through the single
// RAM port; no access is taken until it finishes.
// A stalled output holds the RAM stage; after the sweep the access side stalls only
// when both stages are full.
module cartridge_bank_mapper_core
    import cbm_pkg::*;
#(
    parameter int SAVE_BANKS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [2:0]  i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_mode,
    input  logic [15:0] i_address,
    input  logic [7:0]  i_write_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_read_data,
    output logic        o_rom_fetch,
    output logic [18:0] o_rom_address
);

    localparam int Depth  = SAVE_BANKS * RamBankBytes;
    localparam int AddrW  = $clog2(Depth);
    localparam int FullW  = RamOffW + 2;

    t_req             w_req;
    logic             w_accept;
    logic             w_s1_move;
    logic             w_ram_en;
    logic             w_ram_we;
    logic [AddrW-1:0] w_ram_addr;
    logic [7:0]       w_ram_wdata;
    logic [7:0]       w_ram_rdata;
    logic [FullW-1:0] w_pos;

    logic             r_clearing;
    logic [AddrW-1:0] r_clr_addr;

    logic             r_s1_valid;
    logic             r_s1_ram_rd;
    logic [7:0]       r_s1_fill;
    logic             r_s1_fetch;
    logic [18:0]      r_s1_rom_addr;

    logic             r_out_valid;
    logic [7:0]       r_out_data;
    logic             r_out_fetch;
    logic [18:0]      r_out_rom_addr;

    assign w_s1_move  = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_clearing && (!r_s1_valid || w_s1_move);
    assign w_accept   = i_in_valid && o_in_ready;

    cbm_ctrl #(
        .SAVE_BANKS (SAVE_BANKS)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_accept     (w_accept),
        .i_mode       (i_mode),
        .i_address    (i_address),
        .i_write_data (i_write_data),
        .o_req        (w_req)
    );

    assign w_pos = {w_req.bank, w_req.offset};

    always_comb begin
        if (r_clearing) begin
            w_ram_en    = 1'b1;
            w_ram_we    = 1'b1;
            w_ram_addr  = r_clr_addr;
            w_ram_wdata = 8'h00;
        end else begin
            w_ram_en    = w_accept && (w_req.ram_rd || w_req.ram_wr);
            w_ram_we    = w_req.ram_wr;
            w_ram_addr  = w_pos[AddrW-1:0];
            w_ram_wdata = i_write_data;
        end
    end

    cbm_ram #(
        .WIDTH (8),
        .DEPTH (Depth)
    ) u_save_ram (
        .i_clk   (i_clk),
        .i_en    (w_ram_en),
        .i_we    (w_ram_we),
        .i_addr  (w_ram_addr),
        .i_wdata (w_ram_wdata),
        .o_rdata (w_ram_rdata)
    );

    // clear sweep after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == AddrW'(Depth - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_s1_valid <= 1'b1;
            end else if (w_s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (w_s1_move) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_ram_rd   <= w_req.ram_rd;
            r_s1_fill     <= w_req.fill;
            r_s1_fetch    <= w_req.rom_fetch;
            r_s1_rom_addr <= w_req.rom_address;
        end
        // RAM read data holds while the stage waits: no new read is issued
        if (w_s1_move) begin
            r_out_data     <= r_s1_ram_rd ? w_ram_rdata : r_s1_fill;
            r_out_fetch    <= r_s1_fetch;
            r_out_rom_addr <= r_s1_rom_addr;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_read_data   = r_out_data;
    assign o_rom_fetch   = r_out_fetch;
    assign o_rom_address = r_out_rom_addr;

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import cbm_pkg::*;

    localparam int STALL_LIMIT  = 100000;
    localparam int SAVE_BYTES   = 4 * RamBankBytes;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 180;
    localparam int SETTLE_TICKS = 10;

    typedef struct packed {
        logic        mode;
        logic [15:0] addr;
        logic [7:0]  data;
    } t_cart_access;

    typedef struct packed {
        logic [7:0]  rd;
        logic        fetch;
        logic [18:0] raddr;
    } t_cart_reply;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_index = CFG_MAPPER_IS_MBC1;
    logic [2:0]  i_cfg_data = 3'd0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic        i_mode = ACC_READ;
    logic [15:0] i_address = 16'h0000;
    logic [7:0]  i_write_data = 8'h00;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [7:0]  o_read_data;
    logic        o_rom_fetch;
    logic [18:0] o_rom_address;

    cartridge_bank_mapper_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_mode        (i_mode),
        .i_address     (i_address),
        .i_write_data  (i_write_data),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_read_data   (o_read_data),
        .o_rom_fetch   (o_rom_fetch),
        .o_rom_address (o_rom_address)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // mapper copy: configuration, control registers and save RAM
    logic       cfg_mbc1;
    logic [2:0] cfg_bank_count;
    logic       ram_en;
    logic [4:0] rom_bank;
    logic [1:0] bank_sel;
    logic       bank_mode;
    logic [1:0] act_bank;
    logic [7:0] save_bytes [0:SAVE_BYTES-1];

    t_cart_access accesses_to_send [$];
    t_cart_reply  bus_replies_due [$];

    bit send_idle = 1'b0;
    bit recv_idle = 1'b0;
    bit access_taken = 1'b0;
    bit result_taken = 1'b0;
    int send_gap = 0;
    int recv_stall = 0;
    int quiet_cycles = 0;
    int queued_cnt = 0;
    int taken_cnt = 0;
    int checked_cnt = 0;
    int fault_cnt = 0;
    int fetch_cnt = 0;
    int ram_read_cnt = 0;
    int reg_write_cnt = 0;

    bit       plan_mbc1  [PHASES] = '{1, 1, 1, 0, 1, 1, 1, 0};
    bit [2:0] plan_count [PHASES] = '{4, 1, 2, 4, 3, 0, 4, 0};
    bit       plan_sidle [PHASES] = '{1, 1, 0, 0, 1, 1, 0, 1};
    bit       plan_ridle [PHASES] = '{1, 0, 1, 0, 1, 1, 0, 1};

    // save RAM byte index for a window access, -1 when RAM is off or absent
    function automatic int ram_slot(input logic [15:0] addr);
        logic [1:0] bank;
        if (!ram_en || cfg_bank_count == 3'd0)
            return -1;
        if (cfg_bank_count >= 3'd4)
            bank = act_bank;
        else if (cfg_bank_count >= 3'd2)
            bank = {1'b0, act_bank[0]};
        else
            bank = 2'd0;
        return int'({bank, addr[RamOffW-1:0]});
    endfunction

    function automatic t_cart_reply map_access(input t_cart_access a);
        t_cart_reply r;
        int slot;
        r = '0;
        if (!cfg_mbc1) begin
            if (a.mode == ACC_READ) begin
                r.fetch = 1'b1;
                r.raddr = {3'b000, a.addr};
            end
        end else if (a.mode == ACC_WRITE) begin
            case (a.addr[15:13])
                RGN_RAM_EN:   ram_en = (a.data[3:0] == RAM_EN_KEY);
                RGN_ROM_BANK: rom_bank = (a.data[4:0] == 5'd0) ? 5'd1 : a.data[4:0];
                RGN_RAM_BANK: begin
                    bank_sel = a.data[1:0];
                    if (bank_mode)
                        act_bank = a.data[1:0];
                end
                RGN_MODE: begin
                    bank_mode = a.data[0];
                    if (a.data[0])
                        act_bank = bank_sel;
                end
                RGN_ROM_HI: ;
                default: begin
                    slot = ram_slot(a.addr);
                    if (slot >= 0)
                        save_bytes[slot] = a.data;
                end
            endcase
        end else begin
            case (a.addr[15:13])
                RGN_RAM_EN, RGN_ROM_BANK: begin
                    r.fetch = 1'b1;
                    r.raddr = {3'b000, a.addr};
                end
                RGN_RAM_BANK, RGN_MODE, RGN_ROM_HI: begin
                    r.fetch = 1'b1;
                    r.raddr = {rom_bank, a.addr[RomOffW-1:0]};
                end
                default: begin
                    slot = ram_slot(a.addr);
                    r.rd = (slot >= 0) ? save_bytes[slot] : OPEN_BUS;
                end
            endcase
        end
        return r;
    endfunction

    // RAM window traffic, half of it on a few offsets, plus control writes, ROM reads and some noise
    function automatic t_cart_access make_access();
        t_cart_access a;
        int pick;
        pick = $urandom_range(0, 99);
        a.mode = ACC_WRITE;
        a.data = 8'($urandom);
        if (pick < 8) begin
            a.addr = 16'($urandom_range(16'h0000, 16'h1FFF));
            if ($urandom_range(0, 4) != 0)
                a.data[3:0] = RAM_EN_KEY;
        end else if (pick < 14) begin
            a.addr = 16'($urandom_range(16'h2000, 16'h3FFF));
        end else if (pick < 20) begin
            a.addr = 16'($urandom_range(16'h4000, 16'h5FFF));
        end else if (pick < 25) begin
            a.addr = 16'($urandom_range(16'h6000, 16'h7FFF));
        end else if (pick < 71) begin
            a.addr = 16'($urandom_range(16'hA000, 16'hFFFF));
            if ($urandom_range(0, 1) != 0)
                a.addr[12:4] = '0;
            if (pick >= 47)
                a.mode = ACC_READ;
        end else if (pick < 93) begin
            a.mode = ACC_READ;
            a.addr = 16'($urandom_range(16'h0000, 16'h9FFF));
        end else begin
            a.mode = 1'($urandom);
            a.addr = 16'($urandom);
        end
        return a;
    endfunction

    task automatic queue_access(input logic mode, input logic [15:0] addr,
                                input logic [7:0] data);
        t_cart_access a;
        a.mode = mode;
        a.addr = addr;
        a.data = data;
        accesses_to_send.push_back(a);
        queued_cnt++;
    endtask

    task automatic write_reg(input logic idx, input logic [2:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        if (idx == CFG_MAPPER_IS_MBC1)
            cfg_mbc1 = val[0];
        else
            cfg_bank_count = val;
        reg_write_cnt++;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // hold until every queued word is taken and every reply has come back
    task automatic wait_drained();
        while (taken_cnt != queued_cnt || bus_replies_due.size() != 0)
            @(negedge i_clk);
    endtask

    // access driver: hold a word until taken, then idle for the drawn gap
    always @(negedge i_clk) begin
        if (!(i_in_valid && !access_taken)) begin
            if (i_in_valid)
                send_gap = send_idle ? $urandom_range(0, 15) : 0;
            if (send_gap > 0) begin
                send_gap--;
                i_in_valid <= 1'b0;
            end else if (accesses_to_send.size() != 0) begin
                t_cart_access nxt;
                nxt = accesses_to_send.pop_front();
                i_mode       <= nxt.mode;
                i_address    <= nxt.addr;
                i_write_data <= nxt.data;
                i_in_valid   <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // reply side: stall a drawn number of cycles after each reply
    always @(negedge i_clk) begin
        if (result_taken)
            recv_stall = recv_idle ? $urandom_range(0, 15) : 0;
        if (recv_stall > 0) begin
            recv_stall--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_cart_reply exp_r;
        t_cart_reply got_r;
        access_taken = i_rst_n && i_in_valid && o_in_ready;
        result_taken = i_rst_n && o_out_valid && i_out_ready;
        if (access_taken) begin
            exp_r = map_access('{i_mode, i_address, i_write_data});
            bus_replies_due.push_back(exp_r);
            taken_cnt++;
            if (exp_r.fetch)
                fetch_cnt++;
            else if (i_mode == ACC_READ)
                ram_read_cnt++;
        end
        if (result_taken) begin
            got_r = '{o_read_data, o_rom_fetch, o_rom_address};
            checked_cnt++;
            if (bus_replies_due.size() == 0) begin
                fault_cnt++;
                if (fault_cnt <= 10)
                    $display("%0t: reply with none pending: rd=%02h fetch=%0b addr=%05h",
                             $time, got_r.rd, got_r.fetch, got_r.raddr);
            end else begin
                exp_r = bus_replies_due.pop_front();
                if (got_r.rd !== exp_r.rd || got_r.fetch !== exp_r.fetch
                        || got_r.raddr !== exp_r.raddr) begin
                    fault_cnt++;
                    if (fault_cnt <= 10)
                        $display("%0t: mismatch: expected rd=%02h fetch=%0b addr=%05h",
                                 $time, exp_r.rd, exp_r.fetch, exp_r.raddr,
                                 ", got rd=%02h fetch=%0b addr=%05h",
                                 got_r.rd, got_r.fetch, got_r.raddr);
                end
            end
        end
        if (access_taken || result_taken) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Timeout: %0d cycles with no word moving, %0d replies pending",
                         quiet_cycles, bus_replies_due.size());
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial begin
        cfg_mbc1       = 1'b1;
        cfg_bank_count = 3'd0;
        ram_en         = 1'b0;
        rom_bank       = 5'd1;
        bank_sel       = 2'd0;
        bank_mode      = 1'b0;
        act_bank       = 2'd0;
        foreach (save_bytes[k])
            save_bytes[k] = 8'h00;

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: map extremes, bank zero, window wrap, ignored writes
        write_reg(CFG_RAM_BANK_COUNT, 3'd4);
        queue_access(ACC_READ,  16'h0000, 8'h00);
        queue_access(ACC_READ,  16'h3FFF, 8'hFF);
        queue_access(ACC_READ,  16'h4000, 8'h00);
        queue_access(ACC_WRITE, 16'h2000, 8'h00);
        queue_access(ACC_READ,  16'h5555, 8'hAA);
        queue_access(ACC_WRITE, 16'h3FFF, 8'hE0);
        queue_access(ACC_WRITE, 16'h2100, 8'h1F);
        queue_access(ACC_READ,  16'h7FFF, 8'h00);
        queue_access(ACC_READ,  16'h9FFF, 8'h00);
        queue_access(ACC_READ,  16'hA000, 8'h00);
        queue_access(ACC_WRITE, 16'hA000, 8'h12);
        queue_access(ACC_WRITE, 16'h0000, 8'h0A);
        queue_access(ACC_READ,  16'hA000, 8'h00);
        queue_access(ACC_WRITE, 16'h6000, 8'h01);
        queue_access(ACC_WRITE, 16'h4000, 8'h03);
        queue_access(ACC_WRITE, 16'hA123, 8'h5A);
        queue_access(ACC_READ,  16'hE123, 8'h00);
        queue_access(ACC_WRITE, 16'h8000, 8'h77);
        queue_access(ACC_WRITE, 16'h7FFF, 8'hFE);
        queue_access(ACC_WRITE, 16'h5FFF, 8'h01);
        queue_access(ACC_READ,  16'hA123, 8'h00);
        queue_access(ACC_WRITE, 16'hFFFF, 8'hFF);
        queue_access(ACC_WRITE, 16'h1FFF, 8'h00);
        queue_access(ACC_READ,  16'hBFFF, 8'h00);
        queue_access(ACC_READ,  16'h8000, 8'h00);
        wait_drained();

        // random phases, each under its own register setting
        for (int ph = 0; ph < PHASES; ph++) begin
            write_reg(CFG_MAPPER_IS_MBC1, {2'($urandom), plan_mbc1[ph]});
            write_reg(CFG_RAM_BANK_COUNT, plan_count[ph]);
            send_idle = plan_sidle[ph];
            recv_idle = plan_ridle[ph];
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                accesses_to_send.push_back(make_access());
                queued_cnt++;
            end
            wait_drained();
        end

        repeat (SETTLE_TICKS) @(negedge i_clk);
        $display("Run: %0d bus accesses across %0d register writes, %0d replies compared",
                 taken_cnt, reg_write_cnt, checked_cnt);
        $display("Run: %0d ROM fetches and %0d save RAM reads, %0d faults",
                 fetch_cnt, ram_read_cnt, fault_cnt);
        if (fault_cnt == 0 && bus_replies_due.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
